// ===== hdl/edds_pkg.sv =====
// edds_pkg: shared types, constants and the cordic angle table for the
// edge dislocation displacement sum block. No dependencies.
package edds_pkg;

    localparam int unsigned CORDIC_STEPS = 24;
    localparam logic [25:0] PI_Q24       = 26'd52707179;
    localparam logic [24:0] HALF_PI_Q24  = 25'd26353589;
    localparam logic [31:0] LN2_Q32      = 32'd2977044472;

    // one dislocation as handed to the arithmetic core
    typedef struct packed {
        logic [30:0] a;
        logic [30:0] b;
        logic        dx_neg;
        logic        dy_neg;
        logic        halved;
    } t_job;

    // restoring divider start request
    typedef struct packed {
        logic [63:0] rem;
        logic        q0;
        logic [32:0] bits;
        logic [62:0] den;
        logic [5:0]  steps;
    } t_div_req;

    function automatic logic [23:0] cordic_angle(input logic [4:0] idx);
        logic [23:0] v;
        unique case (idx)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/edds_div.sv =====
// edds_div: shared restoring divider, one quotient bit per cycle.
// Depends on edds_pkg (t_div_req).
module edds_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  edds_pkg::t_div_req i_req,
    output logic               o_busy,
    output logic [33:0]        o_quot
);
    import edds_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [32:0] r_bits;
    logic [62:0] r_den;
    logic [33:0] r_quot;
    logic [63:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem[62:0], r_bits[32]};
    assign fits   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_req.rem;
            r_bits <= i_req.bits;
            r_den  <= i_req.den;
            r_quot <= {33'd0, i_req.q0};
        end else if (r_busy) begin
            r_rem  <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_bits <= {r_bits[31:0], 1'b0};
            r_quot <= {r_quot[32:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// ===== hdl/edds_cordic.sv =====
// edds_cordic: first-quadrant angle of (a, b) by cordic vectoring, Q.24,
// after a five-step binary normalize. Depends on edds_pkg (angle table).
module edds_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [30:0]        i_a,
    input  logic [30:0]        i_b,
    output logic               o_busy,
    output logic signed [26:0] o_angle
);
    import edds_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_NORM = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;

    logic [1:0]         r_state;
    logic [4:0]         r_step;
    logic [30:0]        r_mx;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [26:0] r_z;
    logic [4:0]         sh;
    logic               top_clear;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [26:0] ang;

    assign sh        = 5'd16 >> r_step[2:0];
    assign top_clear = ((r_mx >> (5'd31 - sh)) == 31'd0);
    assign xs        = r_x >>> r_step;
    assign ys        = r_y >>> r_step;
    assign ang       = {3'b000, cordic_angle(r_step)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_start && (i_a != 31'd0) && (i_b != 31'd0)) begin
                        r_state <= C_NORM;
                        r_step  <= '0;
                    end
                end
                C_NORM: begin
                    if (r_step == 5'd4) begin
                        r_state <= C_ITER;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                C_ITER: begin
                    if (r_step == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= C_IDLE;
                    end
                    r_step <= r_step + 5'd1;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    r_mx <= (i_a > i_b) ? i_a : i_b;
                    r_x  <= {3'b000, i_a};
                    r_y  <= {3'b000, i_b};
                    if (i_b == 31'd0) begin
                        r_z <= '0;
                    end else if (i_a == 31'd0) begin
                        r_z <= {2'b00, HALF_PI_Q24};
                    end else begin
                        r_z <= '0;
                    end
                end
            end
            C_NORM: begin
                if (top_clear) begin
                    r_mx <= r_mx << sh;
                    r_x  <= r_x << sh;
                    r_y  <= r_y << sh;
                end
            end
            C_ITER: begin
                if (!r_y[33]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + ang;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - ang;
                end
            end
            default: ;
        endcase
    end

    assign o_busy  = (r_state != C_IDLE);
    assign o_angle = r_z;

endmodule

// ===== hdl/edds_core.sv =====
// edds_core: sequencer around one shared multiplier, the divider and the
// cordic unit; forms both displacement terms. Depends on edds_pkg,
// edds_div and edds_cordic.
module edds_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  edds_pkg::t_job     i_job,
    input  logic signed [16:0] i_nu,
    output logic               o_done,
    output logic signed [39:0] o_term_x,
    output logic signed [39:0] o_term_y
);
    import edds_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_MAA    = 5'd1;
    localparam logic [4:0] S_MBB    = 5'd2;
    localparam logic [4:0] S_MAB    = 5'd3;
    localparam logic [4:0] S_SUMN   = 5'd4;
    localparam logic [4:0] S_LAUNCH = 5'd5;
    localparam logic [4:0] S_LNORM  = 5'd6;
    localparam logic [4:0] S_LMANT  = 5'd7;
    localparam logic [4:0] S_SQMUL  = 5'd8;
    localparam logic [4:0] S_SQUPD  = 5'd9;
    localparam logic [4:0] S_LGMUL  = 5'd10;
    localparam logic [4:0] S_LNCAP  = 5'd11;
    localparam logic [4:0] S_C2MUL  = 5'd12;
    localparam logic [4:0] S_YCAP   = 5'd13;
    localparam logic [4:0] S_WDIV1  = 5'd14;
    localparam logic [4:0] S_WDIV2  = 5'd15;
    localparam logic [4:0] S_WDIV3  = 5'd16;
    localparam logic [4:0] S_WCOR   = 5'd17;
    localparam logic [4:0] S_FIN    = 5'd18;

    logic [4:0]         r_state;
    t_job               r_job;
    logic [61:0]        r_aa;
    logic [61:0]        r_bb;
    logic [61:0]        r_ab;
    logic [62:0]        r_n;
    logic signed [65:0] r_prod;
    logic [62:0]        r_lv;
    logic [5:0]         r_lcnt;
    logic [2:0]         r_lstep;
    logic [31:0]        r_m;
    logic [19:0]        r_f;
    logic [4:0]         r_sq;
    logic signed [23:0] r_ln;
    logic signed [27:0] r_yterm;
    logic [33:0]        r_t1;
    logic [17:0]        r_t2;
    logic               r_done;
    logic signed [39:0] r_term_x;
    logic signed [39:0] r_term_y;

    logic signed [32:0] mul_x;
    logic signed [32:0] mul_y;
    logic [5:0]         lsh;
    logic               ltop_clear;
    logic [32:0]        sq;
    logic signed [7:0]  lexp;
    logic signed [27:0] lg;
    logic signed [65:0] lnsum;
    logic signed [65:0] ysum;
    logic signed [18:0] c2;
    logic [17:0]        h;
    logic [61:0]        num;
    logic               q0;
    logic               div_start;
    t_div_req           div_req;
    logic               div_busy;
    logic [33:0]        quot;
    logic               cor_busy;
    logic signed [26:0] angle;
    logic [33:0]        t2sum;
    logic signed [27:0] th0;
    logic signed [27:0] th1;
    logic signed [27:0] th2;
    logic signed [27:0] thr;
    logic signed [39:0] t1s;

    assign c2 = 19'sd65536 - {i_nu[16], i_nu, 1'b0};
    assign h  = 18'd65536 - {i_nu[16], i_nu};

    // shared multiplier operand select
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        unique case (r_state)
            S_MAA: begin
                mul_x = {2'b00, r_job.a};
                mul_y = {2'b00, r_job.a};
            end
            S_MBB: begin
                mul_x = {2'b00, r_job.b};
                mul_y = {2'b00, r_job.b};
            end
            S_MAB: begin
                mul_x = {2'b00, r_job.a};
                mul_y = {2'b00, r_job.b};
            end
            S_SQMUL: begin
                mul_x = {1'b0, r_m};
                mul_y = {1'b0, r_m};
            end
            S_LGMUL: begin
                mul_x = {{5{lg[27]}}, lg};
                mul_y = {1'b0, LN2_Q32};
            end
            S_C2MUL: begin
                mul_x = {{14{c2[18]}}, c2};
                mul_y = {{9{r_ln[23]}}, r_ln};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_x * mul_y;
    end

    // log2 normalize: shift steps of 32, 16, 8, 4, 2, 1
    assign lsh        = 6'd32 >> r_lstep;
    assign ltop_clear = ((r_lv >> (7'd63 - {1'b0, lsh})) == 63'd0);
    assign sq         = r_prod[63:31];
    // exponent: (62 - shifts) + 2*halved - 32
    assign lexp       = 8'sd30 - $signed({2'b00, r_lcnt}) + $signed({6'd0, r_job.halved, 1'b0});
    assign lg         = {lexp, r_f};
    assign lnsum      = r_prod + (66'sd1 <<< 35);
    assign ysum       = r_prod + (66'sd1 <<< 15);

    // divider request
    assign num = (r_state == S_LAUNCH) ? r_ab : r_bb;
    assign q0  = ({1'b0, num} >= r_n);

    always_comb begin
        if (r_state == S_WDIV1) begin
            div_req.rem   = '0;
            div_req.q0    = 1'b0;
            div_req.bits  = quot[32:0] + {15'd0, h};
            div_req.den   = {44'd0, h, 1'b0};
            div_req.steps = 6'd33;
        end else begin
            div_req.rem   = q0 ? {1'b0, ({1'b0, num} - r_n)} : {2'b00, num};
            div_req.q0    = q0;
            div_req.bits  = '0;
            div_req.den   = r_n;
            div_req.steps = 6'd32;
        end
    end

    assign div_start = (r_state == S_LAUNCH)
                    || ((r_state == S_WDIV1) && !div_busy)
                    || ((r_state == S_WDIV2) && !div_busy);

    edds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    edds_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LAUNCH),
        .i_a     (r_job.a),
        .i_b     (r_job.b),
        .o_busy  (cor_busy),
        .o_angle (angle)
    );

    assign t2sum = {1'b0, quot[32:0]} + 34'd16384;

    // quadrant fold and rounding of the angle
    assign th0 = {angle[26], angle};
    assign th1 = r_job.dx_neg ? ($signed({2'b00, PI_Q24}) - th0) : th0;
    assign th2 = r_job.dy_neg ? -th1 : th1;
    assign thr = th2 + 28'sd128;
    assign t1s = (r_job.dx_neg ^ r_job.dy_neg) ? -$signed({6'd0, r_t1})
                                                : $signed({6'd0, r_t1});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE:   if (i_start) r_state <= S_MAA;
                S_MAA:    r_state <= S_MBB;
                S_MBB:    r_state <= S_MAB;
                S_MAB:    r_state <= S_SUMN;
                S_SUMN:   r_state <= S_LAUNCH;
                S_LAUNCH: r_state <= S_LNORM;
                S_LNORM:  if (r_lstep == 3'd5) r_state <= S_LMANT;
                S_LMANT:  r_state <= S_SQMUL;
                S_SQMUL:  r_state <= S_SQUPD;
                S_SQUPD:  r_state <= (r_sq == 5'd19) ? S_LGMUL : S_SQMUL;
                S_LGMUL:  r_state <= S_LNCAP;
                S_LNCAP:  r_state <= S_C2MUL;
                S_C2MUL:  r_state <= S_YCAP;
                S_YCAP:   r_state <= S_WDIV1;
                S_WDIV1:  if (!div_busy) r_state <= S_WDIV2;
                S_WDIV2:  if (!div_busy) r_state <= S_WDIV3;
                S_WDIV3:  if (!div_busy) r_state <= S_WCOR;
                S_WCOR:   if (!cor_busy) r_state <= S_FIN;
                S_FIN: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE:   if (i_start) r_job <= i_job;
            S_MBB:    r_aa <= r_prod[61:0];
            S_MAB:    r_bb <= r_prod[61:0];
            S_SUMN: begin
                r_ab <= r_prod[61:0];
                r_n  <= {1'b0, r_aa} + {1'b0, r_bb};
            end
            S_LAUNCH: begin
                r_lv    <= r_n;
                r_lcnt  <= '0;
                r_lstep <= '0;
            end
            S_LNORM: begin
                if (ltop_clear) begin
                    r_lv   <= r_lv << lsh;
                    r_lcnt <= r_lcnt + lsh;
                end
                r_lstep <= r_lstep + 3'd1;
            end
            S_LMANT: begin
                r_m  <= r_lv[62:31];
                r_f  <= '0;
                r_sq <= '0;
            end
            S_SQUPD: begin
                if (sq[32]) begin
                    r_m <= sq[32:1];
                    r_f <= {r_f[18:0], 1'b1};
                end else begin
                    r_m <= sq[31:0];
                    r_f <= {r_f[18:0], 1'b0};
                end
                r_sq <= r_sq + 5'd1;
            end
            S_LNCAP:  r_ln <= lnsum[59:36];
            S_YCAP:   r_yterm <= ysum[43:16];
            S_WDIV2:  if (!div_busy) r_t1 <= quot;
            S_WDIV3:  if (!div_busy) r_t2 <= t2sum[32:15];
            S_FIN: begin
                r_term_x <= {{20{thr[27]}}, thr[27:8]} + t1s;
                r_term_y <= {{12{r_yterm[27]}}, r_yterm} - $signed({22'd0, r_t2});
            end
            default: ;
        endcase
    end

    assign o_done   = r_done;
    assign o_term_x = r_term_x;
    assign o_term_y = r_term_y;

endmodule

// ===== hdl/edge_dislocation_displacement_sum.sv =====
// edge_dislocation_displacement_sum: top level; request handshake, run
// bookkeeping and saturating sums. Depends on edds_pkg and edds_core.
//
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_stall   point, dislocation, sense, last
//  out       source     o_out_valid / i_out_stall disp_x, disp_y, flags
//  cfg       sink       i_cfg_we                  i_cfg_data (poisson ratio)
//
// Each request stalls the input until it is done. With active sense (01 or 11),
// 20 log2 squarings on the shared multiplier hide the first 32-step division, then
// 33- and 32-step divisions follow back to back on the divider.
// Skipped, zero-sense and coincident requests bypass the core.
// Reset is synchronous and clears sums, flags and the run count at once.
// A waiting result blocks only the next request that closes a run.
module edge_dislocation_displacement_sum #(
    parameter int MAX_DISLOCATIONS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_disloc_x,
    input  logic signed [31:0] i_disloc_y,
    input  logic signed [1:0]  i_burgers_sense,
    input  logic               i_last_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [47:0] o_disp_x,
    output logic signed [47:0] o_disp_y,
    output logic               o_coincident_seen,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic signed [16:0] i_cfg_data
);
    import edds_pkg::*;

    localparam int CW = $clog2(MAX_DISLOCATIONS + 1);
    localparam logic signed [49:0] SUM_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] SUM_MIN = -50'sh0_8000_0000_0000;

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_PREP = 3'd1;
    localparam logic [2:0] T_CORE = 3'd2;
    localparam logic [2:0] T_ACC  = 3'd3;
    localparam logic [2:0] T_EMIT = 3'd4;

    logic [2:0]         r_state;
    logic [CW-1:0]      r_run;
    logic signed [16:0] r_nu;
    logic signed [47:0] r_sum_x;
    logic signed [47:0] r_sum_y;
    logic               r_coin;
    logic               r_sat;
    logic               r_out_valid;
    logic signed [47:0] r_disp_x;
    logic signed [47:0] r_disp_y;
    logic               r_out_coin;
    logic               r_out_sat;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_qx;
    logic signed [31:0] r_qy;
    logic [1:0]         r_sense;
    logic               r_last;
    logic signed [39:0] r_tx;
    logic signed [39:0] r_ty;

    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic               big;
    t_job               job;
    logic               in_run;
    logic               coincident;
    logic               active;
    logic               core_start;
    logic               core_done;
    logic signed [39:0] term_x;
    logic signed [39:0] term_y;
    logic signed [49:0] vx;
    logic signed [49:0] vy;
    logic               emit_free;
    logic               emit_now;
    logic               sat_now;

    assign dx  = {r_qx[31], r_qx} - {r_px[31], r_px};
    assign dy  = {r_qy[31], r_qy} - {r_py[31], r_py};
    assign ax  = dx[32] ? 33'(-dx) : 33'(dx);
    assign ay  = dy[32] ? 33'(-dy) : 33'(dy);
    assign big = ax[31] | ay[31];

    assign job.a      = big ? ax[31:1] : ax[30:0];
    assign job.b      = big ? ay[31:1] : ay[30:0];
    assign job.dx_neg = dx[32];
    assign job.dy_neg = dy[32];
    assign job.halved = big;

    assign in_run     = (r_run < CW'(MAX_DISLOCATIONS));
    assign coincident = (dx == 33'sd0) && (dy == 33'sd0);
    // sense codes 01 and 11 only; 10 counts as zero
    assign active     = r_sense[0];
    assign core_start = (r_state == T_PREP) && in_run && !coincident && active;

    edds_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (core_start),
        .i_job    (job),
        .i_nu     (r_nu),
        .o_done   (core_done),
        .o_term_x (term_x),
        .o_term_y (term_y)
    );

    assign vx        = {{2{r_sum_x[47]}}, r_sum_x} + {{10{r_tx[39]}}, r_tx};
    assign vy        = {{2{r_sum_y[47]}}, r_sum_y} + {{10{r_ty[39]}}, r_ty};
    assign emit_free = !r_out_valid || !i_out_stall;
    assign emit_now  = (r_state == T_EMIT) && r_last && emit_free;
    assign sat_now   = (vx > SUM_MAX) || (vx < SUM_MIN) || (vy > SUM_MAX) || (vy < SUM_MIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_run       <= '0;
            r_nu        <= 17'sd19661;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_coin      <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_nu <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && !emit_now) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= T_PREP;
                    end
                end
                T_PREP: begin
                    if (in_run) begin
                        r_run <= r_run + CW'(1);
                        if (coincident) begin
                            r_coin <= 1'b1;
                        end
                    end
                    r_state <= core_start ? T_CORE : T_EMIT;
                end
                T_CORE: begin
                    if (core_done) begin
                        r_state <= T_ACC;
                    end
                end
                T_ACC: begin
                    if (vx > SUM_MAX) begin
                        r_sum_x <= SUM_MAX[47:0];
                    end else if (vx < SUM_MIN) begin
                        r_sum_x <= SUM_MIN[47:0];
                    end else begin
                        r_sum_x <= vx[47:0];
                    end
                    if (vy > SUM_MAX) begin
                        r_sum_y <= SUM_MAX[47:0];
                    end else if (vy < SUM_MIN) begin
                        r_sum_y <= SUM_MIN[47:0];
                    end else begin
                        r_sum_y <= vy[47:0];
                    end
                    if (sat_now) begin
                        r_sat <= 1'b1;
                    end
                    r_state <= T_EMIT;
                end
                T_EMIT: begin
                    if (!r_last) begin
                        r_state <= T_IDLE;
                    end else if (emit_free) begin
                        r_out_valid <= 1'b1;
                        r_sum_x     <= '0;
                        r_sum_y     <= '0;
                        r_coin      <= 1'b0;
                        r_sat       <= 1'b0;
                        r_run       <= '0;
                        r_state     <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == T_IDLE) && i_in_valid) begin
            r_px    <= i_point_x;
            r_py    <= i_point_y;
            r_qx    <= i_disloc_x;
            r_qy    <= i_disloc_y;
            r_sense <= i_burgers_sense;
            r_last  <= i_last_item;
        end
        if ((r_state == T_CORE) && core_done) begin
            r_tx <= r_sense[1] ? -term_x : term_x;
            r_ty <= r_sense[1] ? -term_y : term_y;
        end
        if (emit_now) begin
            r_disp_x   <= r_sum_x;
            r_disp_y   <= r_sum_y;
            r_out_coin <= r_coin;
            r_out_sat  <= r_sat;
        end
    end

    assign o_in_stall        = (r_state != T_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_disp_x          = r_disp_x;
    assign o_disp_y          = r_disp_y;
    assign o_coincident_seen = r_out_coin;
    assign o_saturated       = r_out_sat;

endmodule
